// ===== rtl/tiet_pkg.sv =====
`default_nettype none

package tiet_pkg;

  // Default sizes of the table and its fields.
  localparam int unsigned INDEX_BITS_DEF = 6;
  localparam int unsigned ID_BITS_DEF    = 22;
  localparam int unsigned COUNT_BITS_DEF = 32;

  // Command carried by an input beat.
  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_EVENT  = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  // Outcome reported with every result beat.
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_DUP     = 2'd1,
    STATUS_MISSING = 2'd2,
    STATUS_FULL    = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ===== rtl/tiet_if.sv =====
`default_nettype none

// Command channel.
interface tiet_in_if #(
  parameter int unsigned INDEX_BITS = tiet_pkg::INDEX_BITS_DEF,
  parameter int unsigned ID_BITS    = tiet_pkg::ID_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            mode;
  logic [ID_BITS-1:0]    proc_id;
  logic [INDEX_BITS-1:0] slot_index;

  modport source (output valid, mode, proc_id, slot_index, input ready);
  modport sink   (input valid, mode, proc_id, slot_index, output ready);
endinterface

// Result channel.
interface tiet_out_if #(
  parameter int unsigned INDEX_BITS = tiet_pkg::INDEX_BITS_DEF,
  parameter int unsigned ID_BITS    = tiet_pkg::ID_BITS_DEF,
  parameter int unsigned COUNT_BITS = tiet_pkg::COUNT_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic                  entry_valid;
  logic [ID_BITS-1:0]    entry_id;
  logic [COUNT_BITS-1:0] event_count;
  logic [INDEX_BITS:0]   tracked_total;

  modport source (output valid, status, entry_valid, entry_id, event_count, tracked_total,
                  input ready);
  modport sink   (input valid, status, entry_valid, entry_id, event_count, tracked_total,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/tiet_ram.sv =====
`default_nettype none

module tiet_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [ADDR_BITS-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]     wdata_i,
  input  wire logic                 re_i,
  input  wire logic [ADDR_BITS-1:0] raddr_i,
  output logic      [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tiet_core.sv =====
`default_nettype none

module tiet_core #(
  parameter int unsigned INDEX_BITS = tiet_pkg::INDEX_BITS_DEF,
  parameter int unsigned ID_BITS    = tiet_pkg::ID_BITS_DEF,
  parameter int unsigned COUNT_BITS = tiet_pkg::COUNT_BITS_DEF,
  localparam int unsigned WORD_BITS = 1 + ID_BITS + COUNT_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Command side.
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            in_mode_i,
  input  wire logic [ID_BITS-1:0]    in_proc_id_i,
  input  wire logic [INDEX_BITS-1:0] in_slot_index_i,
  // Result side.
  output logic                       res_valid_o,
  input  wire logic                  res_ready_i,
  output logic      [1:0]            res_status_o,
  output logic                       res_entry_valid_o,
  output logic      [ID_BITS-1:0]    res_entry_id_o,
  output logic      [COUNT_BITS-1:0] res_event_count_o,
  output logic      [INDEX_BITS:0]   res_tracked_total_o,
  // Slot memory.
  output logic                       mem_we_o,
  output logic      [INDEX_BITS-1:0] mem_waddr_o,
  output logic      [WORD_BITS-1:0]  mem_wdata_o,
  output logic                       mem_re_o,
  output logic      [INDEX_BITS-1:0] mem_raddr_o,
  input  wire logic [WORD_BITS-1:0]  mem_rdata_i
);

  import tiet_pkg::*;

  localparam logic [INDEX_BITS-1:0] LAST_SLOT = '1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  state_e                state_q, state_d;
  logic [INDEX_BITS-1:0] addr_q, addr_d;
  logic                  issued_all_q, issued_all_d;
  logic                  chk_vld_q, chk_vld_d;
  logic [INDEX_BITS-1:0] chk_addr_q, chk_addr_d;
  logic                  chk_last_q, chk_last_d;
  mode_e                 mode_q, mode_d;
  logic [ID_BITS-1:0]    key_q, key_d;
  logic                  free_vld_q, free_vld_d;
  logic [INDEX_BITS-1:0] free_idx_q, free_idx_d;
  logic [INDEX_BITS:0]   occ_q, occ_d;
  status_e               res_status_q, res_status_d;
  logic                  res_valid_q, res_valid_d;
  logic [ID_BITS-1:0]    res_id_q, res_id_d;
  logic [COUNT_BITS-1:0] res_count_q, res_count_d;
  logic [INDEX_BITS:0]   res_total_q, res_total_d;

  logic                  rd_used;
  logic [ID_BITS-1:0]    rd_id;
  logic [COUNT_BITS-1:0] rd_count;
  logic                  rd_hit;

  // Slot word layout: used flag, ID, counter.
  assign rd_used  = mem_rdata_i[WORD_BITS-1];
  assign rd_id    = mem_rdata_i[COUNT_BITS +: ID_BITS];
  assign rd_count = mem_rdata_i[COUNT_BITS-1:0];
  assign rd_hit   = rd_used && (rd_id == key_q);

  // Sequencer: clearing pass, then one command at a time, reading the addressed slot or scanning the slots.
  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    issued_all_d = issued_all_q;
    chk_vld_d    = chk_vld_q;
    chk_addr_d   = chk_addr_q;
    chk_last_d   = chk_last_q;
    mode_d       = mode_q;
    key_d        = key_q;
    free_vld_d   = free_vld_q;
    free_idx_d   = free_idx_q;
    occ_d        = occ_q;
    res_status_d = res_status_q;
    res_valid_d  = res_valid_q;
    res_id_d     = res_id_q;
    res_count_d  = res_count_q;
    res_total_d  = res_total_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = chk_addr_q;
    mem_wdata_o  = '0;
    mem_re_o     = 1'b0;
    mem_raddr_o  = addr_q;

    case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = addr_q;
        addr_d      = addr_q + INDEX_BITS'(1);
        if (addr_q == LAST_SLOT) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          mem_re_o   = 1'b1;
          mode_d     = mode_e'(in_mode_i);
          key_d      = in_proc_id_i;
          free_vld_d = 1'b0;
          chk_vld_d  = 1'b1;
          state_d    = ST_SCAN;
          if (mode_e'(in_mode_i) == MODE_READ) begin
            mem_raddr_o  = in_slot_index_i;
            issued_all_d = 1'b1;
            chk_last_d   = 1'b1;
          end else begin
            mem_raddr_o  = '0;
            addr_d       = INDEX_BITS'(1);
            issued_all_d = 1'b0;
            chk_last_d   = 1'b0;
          end
          chk_addr_d = mem_raddr_o;
        end
      end

      ST_SCAN: begin
        // Issue the next slot read while the previous one is checked.
        chk_vld_d = 1'b0;
        if (!issued_all_q) begin
          mem_re_o     = 1'b1;
          mem_raddr_o  = addr_q;
          chk_vld_d    = 1'b1;
          chk_addr_d   = addr_q;
          chk_last_d   = (addr_q == LAST_SLOT);
          issued_all_d = (addr_q == LAST_SLOT);
          addr_d       = addr_q + INDEX_BITS'(1);
        end

        if (chk_vld_q) begin
          res_valid_d  = 1'b0;
          res_id_d     = '0;
          res_count_d  = '0;
          res_status_d = STATUS_OK;
          case (mode_q)
            MODE_READ: begin
              res_valid_d = rd_used;
              res_id_d    = rd_used ? rd_id : '0;
              res_count_d = rd_used ? rd_count : '0;
              state_d     = ST_RESP;
            end
            MODE_ADD: begin
              if (rd_hit) begin
                res_status_d = STATUS_DUP;
                res_id_d     = key_q;
                res_count_d  = rd_count;
                state_d      = ST_RESP;
              end else if (chk_last_q) begin
                if (free_vld_q || !rd_used) begin
                  mem_we_o    = 1'b1;
                  mem_waddr_o = free_vld_q ? free_idx_q : chk_addr_q;
                  mem_wdata_o = {1'b1, key_q, {COUNT_BITS{1'b0}}};
                  occ_d       = occ_q + (INDEX_BITS+1)'(1);
                  res_id_d    = key_q;
                end else begin
                  res_status_d = STATUS_FULL;
                end
                state_d = ST_RESP;
              end else if (!rd_used && !free_vld_q) begin
                free_vld_d = 1'b1;
                free_idx_d = chk_addr_q;
              end
            end
            MODE_REMOVE: begin
              if (rd_hit) begin
                mem_we_o    = 1'b1;
                mem_wdata_o = '0;
                if (occ_q != '0) begin
                  occ_d = occ_q - (INDEX_BITS+1)'(1);
                end
                res_id_d    = key_q;
                res_count_d = rd_count;
                state_d     = ST_RESP;
              end else if (chk_last_q) begin
                res_status_d = STATUS_MISSING;
                state_d      = ST_RESP;
              end
            end
            MODE_EVENT: begin
              if (rd_hit) begin
                mem_we_o    = 1'b1;
                mem_wdata_o = {1'b1, key_q, rd_count + COUNT_BITS'(1)};
                res_id_d    = key_q;
                res_count_d = rd_count + COUNT_BITS'(1);
                state_d     = ST_RESP;
              end else if (chk_last_q) begin
                res_status_d = STATUS_MISSING;
                state_d      = ST_RESP;
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
          if (state_d == ST_RESP) begin
            chk_vld_d   = 1'b0;
            res_total_d = occ_d;
          end
        end
      end

      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      addr_q       <= '0;
      issued_all_q <= 1'b0;
      chk_vld_q    <= 1'b0;
      chk_addr_q   <= '0;
      chk_last_q   <= 1'b0;
      mode_q       <= MODE_ADD;
      key_q        <= '0;
      free_vld_q   <= 1'b0;
      free_idx_q   <= '0;
      occ_q        <= '0;
      res_status_q <= STATUS_OK;
      res_valid_q  <= 1'b0;
      res_id_q     <= '0;
      res_count_q  <= '0;
      res_total_q  <= '0;
    end else begin
      state_q      <= state_d;
      addr_q       <= addr_d;
      issued_all_q <= issued_all_d;
      chk_vld_q    <= chk_vld_d;
      chk_addr_q   <= chk_addr_d;
      chk_last_q   <= chk_last_d;
      mode_q       <= mode_d;
      key_q        <= key_d;
      free_vld_q   <= free_vld_d;
      free_idx_q   <= free_idx_d;
      occ_q        <= occ_d;
      res_status_q <= res_status_d;
      res_valid_q  <= res_valid_d;
      res_id_q     <= res_id_d;
      res_count_q  <= res_count_d;
      res_total_q  <= res_total_d;
    end
  end

  assign in_ready_o          = (state_q == ST_IDLE);
  assign res_valid_o         = (state_q == ST_RESP);
  assign res_status_o        = res_status_q;
  assign res_entry_valid_o   = res_valid_q;
  assign res_entry_id_o      = res_id_q;
  assign res_event_count_o   = res_count_q;
  assign res_tracked_total_o = res_total_q;

endmodule

`default_nettype wire

// ===== rtl/tracked_id_event_counter_table.sv =====
`default_nettype none

// Channel  Dir  Fields
// in_i     in   mode, proc_id, slot_index
// out_o    out  status, entry_valid, entry_id, event_count, tracked_total
//
// Slots live in one memory with a single read port; lookups read one slot per cycle.
// A read command reads only the addressed slot; a lookup scans from slot 0 and stops at a match,
// and a miss or a fresh add scans every slot.
// After reset a clearing pass writes every slot before in_i.ready rises.
// A result waits in the output register while the next command is taken and scanned.

module tracked_id_event_counter_table #(
  parameter int unsigned INDEX_BITS = tiet_pkg::INDEX_BITS_DEF,
  parameter int unsigned ID_BITS    = tiet_pkg::ID_BITS_DEF,
  parameter int unsigned COUNT_BITS = tiet_pkg::COUNT_BITS_DEF
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  tiet_in_if.sink    in_i,
  tiet_out_if.source out_o
);

  import tiet_pkg::*;

  localparam int unsigned WORD_BITS = 1 + ID_BITS + COUNT_BITS;
  localparam int unsigned SLOTS     = 1 << INDEX_BITS;

  logic                  res_valid;
  logic                  res_ready;
  logic [1:0]            res_status;
  logic                  res_entry_valid;
  logic [ID_BITS-1:0]    res_entry_id;
  logic [COUNT_BITS-1:0] res_event_count;
  logic [INDEX_BITS:0]   res_tracked_total;

  logic                  mem_we;
  logic [INDEX_BITS-1:0] mem_waddr;
  logic [WORD_BITS-1:0]  mem_wdata;
  logic                  mem_re;
  logic [INDEX_BITS-1:0] mem_raddr;
  logic [WORD_BITS-1:0]  mem_rdata;

  logic                  out_vld_q;
  logic [1:0]            out_status_q;
  logic                  out_entry_valid_q;
  logic [ID_BITS-1:0]    out_entry_id_q;
  logic [COUNT_BITS-1:0] out_event_count_q;
  logic [INDEX_BITS:0]   out_tracked_total_q;

  tiet_core #(
    .INDEX_BITS (INDEX_BITS),
    .ID_BITS    (ID_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_i.valid),
    .in_ready_o          (in_i.ready),
    .in_mode_i           (in_i.mode),
    .in_proc_id_i        (in_i.proc_id),
    .in_slot_index_i     (in_i.slot_index),
    .res_valid_o         (res_valid),
    .res_ready_i         (res_ready),
    .res_status_o        (res_status),
    .res_entry_valid_o   (res_entry_valid),
    .res_entry_id_o      (res_entry_id),
    .res_event_count_o   (res_event_count),
    .res_tracked_total_o (res_tracked_total),
    .mem_we_o            (mem_we),
    .mem_waddr_o         (mem_waddr),
    .mem_wdata_o         (mem_wdata),
    .mem_re_o            (mem_re),
    .mem_raddr_o         (mem_raddr),
    .mem_rdata_i         (mem_rdata)
  );

  tiet_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: takes a finished result when empty or being drained.
  assign res_ready = !out_vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_status_q        <= res_status;
      out_entry_valid_q   <= res_entry_valid;
      out_entry_id_q      <= res_entry_id;
      out_event_count_q   <= res_event_count;
      out_tracked_total_q <= res_tracked_total;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.status        = out_status_q;
  assign out_o.entry_valid   = out_entry_valid_q;
  assign out_o.entry_id      = out_entry_id_q;
  assign out_o.event_count   = out_event_count_q;
  assign out_o.tracked_total = out_tracked_total_q;

`ifndef SYNTHESIS
  // Only one command is in flight: ready drops right after a beat is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("command accepted while another is in flight");

  // The tracked count never exceeds the number of slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.tracked_total <= (INDEX_BITS+1)'(SLOTS))
    else $error("tracked total exceeds table size");

  // A slot report always carries an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.entry_valid |-> out_o.status == STATUS_OK)
    else $error("slot report with error status");

  // Failed lookups and a full table report no entry data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status == STATUS_MISSING || out_o.status == STATUS_FULL)
      |-> out_o.entry_id == '0 && out_o.event_count == '0)
    else $error("error result carries entry data");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_tracked_id_event_counter_table.sv =====
`timescale 1ns / 100ps

import tiet_pkg::*;

// Keeps its own copy of the slot table, predicts one result per command beat
// and checks result beats in order against those predictions.
class tracked_table_scoreboard;
  localparam int unsigned IDX_W = INDEX_BITS_DEF;
  localparam int unsigned ID_W  = ID_BITS_DEF;
  localparam int unsigned CNT_W = COUNT_BITS_DEF;
  localparam int unsigned SLOTS = 1 << IDX_W;
  localparam int unsigned PRINT_CAP = 40;

  typedef struct packed {
    status_e            status;
    logic               entry_valid;
    logic [ID_W-1:0]    entry_id;
    logic [CNT_W-1:0]   event_count;
    logic [IDX_W:0]     tracked_total;
  } table_result_t;

  bit               slot_used  [SLOTS];
  logic [ID_W-1:0]  slot_id    [SLOTS];
  logic [CNT_W-1:0] slot_count [SLOTS];
  logic [IDX_W:0]   occupancy;

  table_result_t expected_q[$];

  int errors;
  int commands_noted;
  int results_checked;
  int peak_occupancy;
  int status_tally[4];
  logic [CNT_W-1:0] peak_count;

  function new();
    foreach (slot_used[k]) begin
      slot_used[k]  = 1'b0;
      slot_id[k]    = '0;
      slot_count[k] = '0;
    end
    occupancy       = '0;
    errors          = 0;
    commands_noted  = 0;
    results_checked = 0;
    peak_occupancy  = 0;
    peak_count      = '0;
    foreach (status_tally[k]) status_tally[k] = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Slot that holds a tracked ID, or -1.
  function int find_slot(logic [ID_W-1:0] pid);
    for (int k = 0; k < SLOTS; k++) begin
      if (slot_used[k] && slot_id[k] == pid) return k;
    end
    return -1;
  endfunction

  // Applies one accepted command to the table copy and queues its result.
  function void note_command(mode_e mode, logic [ID_W-1:0] pid, logic [IDX_W-1:0] sidx);
    table_result_t r;
    int hit;
    int free_slot;
    r = '0;
    r.status = STATUS_OK;
    case (mode)
      MODE_ADD: begin
        hit = find_slot(pid);
        if (hit >= 0) begin
          r.status      = STATUS_DUP;
          r.entry_id    = pid;
          r.event_count = slot_count[hit];
        end else begin
          // New IDs take the lowest free slot.
          free_slot = -1;
          for (int k = SLOTS - 1; k >= 0; k--) begin
            if (!slot_used[k]) free_slot = k;
          end
          if (free_slot < 0) begin
            r.status = STATUS_FULL;
          end else begin
            slot_used[free_slot]  = 1'b1;
            slot_id[free_slot]    = pid;
            slot_count[free_slot] = '0;
            occupancy++;
            r.entry_id = pid;
          end
        end
      end
      MODE_REMOVE: begin
        hit = find_slot(pid);
        if (hit < 0) begin
          r.status = STATUS_MISSING;
        end else begin
          r.entry_id      = pid;
          r.event_count   = slot_count[hit];
          slot_used[hit]  = 1'b0;
          slot_id[hit]    = '0;
          slot_count[hit] = '0;
          occupancy--;
        end
      end
      MODE_EVENT: begin
        hit = find_slot(pid);
        if (hit < 0) begin
          r.status = STATUS_MISSING;
        end else begin
          // The counter wraps naturally at its width.
          slot_count[hit] = slot_count[hit] + 1'b1;
          r.entry_id      = pid;
          r.event_count   = slot_count[hit];
        end
      end
      default: begin
        if (slot_used[sidx]) begin
          r.entry_valid = 1'b1;
          r.entry_id    = slot_id[sidx];
          r.event_count = slot_count[sidx];
        end
      end
    endcase
    r.tracked_total = occupancy;
    if (int'(occupancy) > peak_occupancy) peak_occupancy = occupancy;
    if (r.event_count > peak_count) peak_count = r.event_count;
    status_tally[r.status]++;
    commands_noted++;
    expected_q.push_back(r);
  endfunction

  task report(string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Compares one result beat with the oldest prediction, field by field.
  task check_result(logic [1:0] status, logic entry_valid, logic [ID_W-1:0] entry_id,
                    logic [CNT_W-1:0] event_count, logic [IDX_W:0] tracked_total);
    table_result_t exp_r;
    if (expected_q.size() == 0) begin
      report($sformatf("result beat with none expected (status %0d id 0x%0h)",
                       status, entry_id));
      return;
    end
    exp_r = expected_q.pop_front();
    results_checked++;
    if (status !== exp_r.status)
      report($sformatf("result %0d status %0d, expected %s", results_checked, status,
                       exp_r.status.name()));
    if (entry_valid !== exp_r.entry_valid)
      report($sformatf("result %0d entry_valid %b, expected %b", results_checked,
                       entry_valid, exp_r.entry_valid));
    if (entry_id !== exp_r.entry_id)
      report($sformatf("result %0d entry_id 0x%0h, expected 0x%0h", results_checked,
                       entry_id, exp_r.entry_id));
    if (event_count !== exp_r.event_count)
      report($sformatf("result %0d event_count %0d, expected %0d", results_checked,
                       event_count, exp_r.event_count));
    if (tracked_total !== exp_r.tracked_total)
      report($sformatf("result %0d tracked_total %0d, expected %0d", results_checked,
                       tracked_total, exp_r.tracked_total));
  endtask
endclass

module tb_tracked_id_event_counter_table;
  localparam int unsigned IDX_W        = INDEX_BITS_DEF;
  localparam int unsigned ID_W         = ID_BITS_DEF;
  localparam int unsigned SLOTS        = 1 << IDX_W;
  localparam int unsigned POOL_SIZE    = 96;
  localparam int unsigned NUM_ROUNDS   = 7;
  localparam int unsigned ROUND_ITEMS  = 250;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned SETTLE_LIMIT = 2 * SLOTS + 20;
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam logic [ID_W-1:0] ID_ALL   = {ID_W{1'b1}};

  logic clk_i = 1'b0;
  logic rst_ni;

  tiet_in_if  cmd_if ();
  tiet_out_if res_if ();

  tracked_table_scoreboard sb = new();

  // Shared between the command driver and the result sink (quiet_cycles feeds the watchdog).
  bit hold_request = 1'b0;
  bit no_idle      = 1'b0;
  int quiet_cycles = 0;

  tracked_id_event_counter_table i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  always #5 clk_i = ~clk_i;

  // Gap before a command: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (no_idle || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one command beat and waits until it is taken.
  task automatic send_command(input mode_e mode, input logic [ID_W-1:0] pid,
                              input logic [IDX_W-1:0] sidx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.mode       <= mode;
    cmd_if.proc_id    <= pid;
    cmd_if.slot_index <= sidx;
    do @(posedge clk_i); while (!cmd_if.ready);
    sb.note_command(mode, pid, sidx);
  endtask

  // Stops offering and waits for every predicted result to arrive.
  task automatic wait_for_drain();
    cmd_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Result sink: checks accepted beats and throttles ready.
  initial begin : result_sink
    int run_left;
    int hold_left;
    bit ready_next;
    run_left     = 0;
    hold_left    = 0;
    ready_next   = 1'b0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready)
        sb.check_result(res_if.status, res_if.entry_valid, res_if.entry_id,
                        res_if.event_count, res_if.tracked_total);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (no_idle) begin
        ready_next = 1'b1;
        run_left   = 0;
      end else begin
        if (run_left == 0) begin
          ready_next = ($urandom_range(99) < 65);
          if (ready_next) run_left = $urandom_range(1, 20);
          else if ($urandom_range(9) == 0) run_left = $urandom_range(20, 60);
          else run_left = $urandom_range(1, 3);
        end
        run_left--;
      end
      res_if.ready <= ready_next;
    end
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timed out after %0d cycles with no beat.", QUIET_LIMIT);
      $display("tb_tracked_id_event_counter_table: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : command_driver
    logic [ID_W-1:0] id_pool [POOL_SIZE];
    logic [ID_W-1:0] pid;
    mode_e mode;
    int roll;
    int add_w;
    int rem_w;
    int evt_w;

    cmd_if.valid      = 1'b0;
    cmd_if.mode       = MODE_ADD;
    cmd_if.proc_id    = '0;
    cmd_if.slot_index = '0;
    rst_ni            = 1'b0;

    foreach (id_pool[k]) id_pool[k] = ID_W'($urandom);
    id_pool[0] = '0;
    id_pool[1] = ID_ALL;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty reads, misses, duplicates, counting, freeing and reuse of slots.
    send_command(MODE_READ,   ID_W'($urandom), '0);
    send_command(MODE_READ,   ID_W'($urandom), {IDX_W{1'b1}});
    send_command(MODE_EVENT,  '0, IDX_W'($urandom));
    send_command(MODE_REMOVE, ID_ALL, IDX_W'($urandom));
    send_command(MODE_ADD,    '0, IDX_W'($urandom));
    send_command(MODE_ADD,    ID_ALL, IDX_W'($urandom));
    send_command(MODE_ADD,    '0, IDX_W'($urandom));
    send_command(MODE_EVENT,  ID_ALL, IDX_W'($urandom));
    send_command(MODE_EVENT,  ID_ALL, IDX_W'($urandom));
    send_command(MODE_ADD,    ID_ALL, IDX_W'($urandom));
    send_command(MODE_READ,   ID_W'($urandom), IDX_W'(1));
    send_command(MODE_REMOVE, '0, IDX_W'($urandom));
    send_command(MODE_READ,   ID_W'($urandom), '0);
    send_command(MODE_ADD,    22'h155555, IDX_W'($urandom));
    send_command(MODE_EVENT,  22'h155555, IDX_W'($urandom));
    send_command(MODE_READ,   ID_W'($urandom), '0);
    send_command(MODE_REMOVE, ID_ALL, IDX_W'($urandom));
    send_command(MODE_READ,   ID_W'($urandom), IDX_W'(1));
    send_command(MODE_ADD,    22'h2aaaaa, IDX_W'($urandom));
    send_command(MODE_REMOVE, 22'h155555, IDX_W'($urandom));
    send_command(MODE_READ,   ID_W'($urandom), IDX_W'(1));

    // Random rounds: fill, churn, drain and event-heavy mixes over a shared ID pool.
    for (int round = 0; round < NUM_ROUNDS; round++) begin
      if (round == 4) wait_for_drain();
      if (round == 1) hold_request = 1'b1;
      no_idle = (round == 3 || round == 5);
      case (round % 4)
        0:       begin add_w = 55; rem_w = 5;  evt_w = 25; end
        1:       begin add_w = 25; rem_w = 25; evt_w = 35; end
        2:       begin add_w = 10; rem_w = 50; evt_w = 25; end
        default: begin add_w = 20; rem_w = 10; evt_w = 55; end
      endcase
      for (int n = 0; n < ROUND_ITEMS; n++) begin
        roll = $urandom_range(99);
        if (roll < add_w) mode = MODE_ADD;
        else if (roll < add_w + rem_w) mode = MODE_REMOVE;
        else if (roll < add_w + rem_w + evt_w) mode = MODE_EVENT;
        else mode = MODE_READ;
        // A tenth of the IDs come from outside the pool and mostly miss.
        if ($urandom_range(9) == 0) pid = ID_W'($urandom);
        else pid = id_pool[$urandom_range(POOL_SIZE - 1)];
        send_command(mode, pid, IDX_W'($urandom));
      end
    end
    no_idle = 1'b0;

    wait_for_drain();
    repeat (SETTLE_LIMIT) @(posedge clk_i);

    $display("Covered %0d commands and %0d results: %0d ok, %0d duplicate, %0d not found, %0d full.",
             sb.commands_noted, sb.results_checked, sb.status_tally[STATUS_OK],
             sb.status_tally[STATUS_DUP], sb.status_tally[STATUS_MISSING],
             sb.status_tally[STATUS_FULL]);
    $display("Table reached %0d of %0d slots; highest counter returned %0d; %0d mismatches.",
             sb.peak_occupancy, SLOTS, sb.peak_count, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_tracked_id_event_counter_table: PASS");
    end else begin
      $display("tb_tracked_id_event_counter_table: FAIL");
    end
    $finish;
  end

endmodule

// ===== tracked_id_event_counter_table.f =====
rtl/tiet_pkg.sv
rtl/tiet_if.sv
rtl/tiet_ram.sv
rtl/tiet_core.sv
rtl/tracked_id_event_counter_table.sv
tb/sv/tb_tracked_id_event_counter_table.sv
